[hdl/rgb2hsv_pkg.sv]
// ----------------------------------------------------------------------------
// rgb2hsv_pkg
// Shared widths, types and the pipeline payload of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

	localparam int CH_W       = 8;
	localparam int HUE_W      = 16;
	localparam int SAT_W      = 8;
	// 6 * delta fits 11 bits (6 * 255 = 1530)
	localparam int HDIV_W     = 11;
	localparam int SATN_W     = 2 * CH_W;
	localparam int DIV_STAGES = 4;
	localparam int HUE_STEPS  = HUE_W / DIV_STAGES;
	localparam int SAT_STEPS  = SAT_W / DIV_STAGES;

	typedef logic [CH_W-1:0] chan_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// State of both restoring dividers as an item moves down the pipeline
	typedef struct packed {
		logic [HDIV_W-1:0] hue_rem;
		logic [HDIV_W-1:0] hue_div;
		logic [HUE_W-1:0]  hue_q;
		chan_t             sat_rem;
		chan_t             sat_lo;
		chan_t             sat_div;
		logic [SAT_W-1:0]  sat_q;
		logic              grey;
		chan_t             brightness;
		chan_t             alpha;
	} div_t;

endpackage

[hdl/rgb2hsv_front.sv]
// ----------------------------------------------------------------------------
// rgb2hsv_front
// First two stages: max/min and sector pick, then delta, hue numerator and
// the operands of the hue and saturation dividers.
// ----------------------------------------------------------------------------
module rgb2hsv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                v_in,
	input  rgb2hsv_pkg::chan_t  red,
	input  rgb2hsv_pkg::chan_t  green,
	input  rgb2hsv_pkg::chan_t  blue,
	input  rgb2hsv_pkg::chan_t  alpha_in,
	output logic                v_out,
	output rgb2hsv_pkg::div_t   d_out
);

	localparam int NUM_W = rgb2hsv_pkg::HDIV_W + 1;

	rgb2hsv_pkg::chan_t    max_rg, min_rg, mx, mn;
	rgb2hsv_pkg::sector_t  sec;

	logic                  v_s1;
	rgb2hsv_pkg::chan_t    red_s1, green_s1, blue_s1, alpha_s1, mx_s1, mn_s1;
	rgb2hsv_pkg::sector_t  sec_s1;

	rgb2hsv_pkg::chan_t                 dlt;
	logic [rgb2hsv_pkg::HDIV_W-1:0]     d6;
	logic [NUM_W-1:0]                   num;
	logic [rgb2hsv_pkg::SATN_W-1:0]     satn;
	rgb2hsv_pkg::div_t                  nxt;

	// Stage 1: extremes and sector, ties go red, then green, then blue
	always_comb begin
		max_rg = (red > green) ? red : green;
		min_rg = (red < green) ? red : green;
		mx     = (max_rg > blue) ? max_rg : blue;
		mn     = (min_rg < blue) ? min_rg : blue;
		if (mx == red) begin
			sec = rgb2hsv_pkg::SEC_RED;
		end else if (mx == green) begin
			sec = rgb2hsv_pkg::SEC_GREEN;
		end else begin
			sec = rgb2hsv_pkg::SEC_BLUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			alpha_s1 <= alpha_in;
			mx_s1    <= mx;
			mn_s1    <= mn;
			sec_s1   <= sec;
		end
	end

	// Stage 2: numerator in [0, 6d), divisor 6d, saturation dividend d*255
	always_comb begin
		dlt = mx_s1 - mn_s1;
		d6  = rgb2hsv_pkg::HDIV_W'({dlt, 2'b00}) + rgb2hsv_pkg::HDIV_W'({dlt, 1'b0});
		case (sec_s1)
			rgb2hsv_pkg::SEC_RED: begin
				num = NUM_W'(green_s1) - NUM_W'(blue_s1);
			end
			rgb2hsv_pkg::SEC_GREEN: begin
				num = NUM_W'({dlt, 1'b0}) + NUM_W'(blue_s1) - NUM_W'(red_s1);
			end
			rgb2hsv_pkg::SEC_BLUE: begin
				num = NUM_W'({dlt, 2'b00}) + NUM_W'(red_s1) - NUM_W'(green_s1);
			end
			default: begin
				num = '0;
			end
		endcase
		if (num[NUM_W-1]) begin
			num = num + NUM_W'(d6);
		end
		satn = rgb2hsv_pkg::SATN_W'({dlt, 8'h00}) - rgb2hsv_pkg::SATN_W'(dlt);

		nxt.hue_rem    = num[rgb2hsv_pkg::HDIV_W-1:0];
		nxt.hue_div    = d6;
		nxt.hue_q      = '0;
		nxt.sat_rem    = satn[rgb2hsv_pkg::SATN_W-1:rgb2hsv_pkg::CH_W];
		nxt.sat_lo     = satn[rgb2hsv_pkg::CH_W-1:0];
		nxt.sat_div    = mx_s1;
		nxt.sat_q      = '0;
		nxt.grey       = (dlt == '0);
		nxt.brightness = mx_s1;
		nxt.alpha      = alpha_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

[hdl/rgb2hsv_div_stage.sv]
// ----------------------------------------------------------------------------
// rgb2hsv_div_stage
// One registered slice of the restoring dividers: a few hue quotient bits
// and a few saturation quotient bits per stage.
// ----------------------------------------------------------------------------
module rgb2hsv_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               v_in,
	input  rgb2hsv_pkg::div_t  d_in,
	output logic               v_out,
	output rgb2hsv_pkg::div_t  d_out
);

	logic [rgb2hsv_pkg::HDIV_W-1:0] hr;
	logic [rgb2hsv_pkg::HDIV_W:0]   ht;
	logic [rgb2hsv_pkg::HUE_W-1:0]  hq;
	rgb2hsv_pkg::chan_t             sr, sl;
	logic [rgb2hsv_pkg::CH_W:0]     st;
	logic [rgb2hsv_pkg::SAT_W-1:0]  sq;
	rgb2hsv_pkg::div_t              nxt;

	always_comb begin
		hr = d_in.hue_rem;
		hq = d_in.hue_q;
		ht = '0;
		for (int i = 0; i < rgb2hsv_pkg::HUE_STEPS; i++) begin
			ht = {hr, 1'b0};
			if (ht >= {1'b0, d_in.hue_div}) begin
				hr = rgb2hsv_pkg::HDIV_W'(ht - {1'b0, d_in.hue_div});
				hq = {hq[rgb2hsv_pkg::HUE_W-2:0], 1'b1};
			end else begin
				hr = ht[rgb2hsv_pkg::HDIV_W-1:0];
				hq = {hq[rgb2hsv_pkg::HUE_W-2:0], 1'b0};
			end
		end

		sr = d_in.sat_rem;
		sl = d_in.sat_lo;
		sq = d_in.sat_q;
		st = '0;
		for (int j = 0; j < rgb2hsv_pkg::SAT_STEPS; j++) begin
			st = {sr, sl[rgb2hsv_pkg::CH_W-1]};
			sl = {sl[rgb2hsv_pkg::CH_W-2:0], 1'b0};
			if (st >= {1'b0, d_in.sat_div}) begin
				sr = rgb2hsv_pkg::CH_W'(st - {1'b0, d_in.sat_div});
				sq = {sq[rgb2hsv_pkg::SAT_W-2:0], 1'b1};
			end else begin
				sr = st[rgb2hsv_pkg::CH_W-1:0];
				sq = {sq[rgb2hsv_pkg::SAT_W-2:0], 1'b0};
			end
		end

		nxt         = d_in;
		nxt.hue_rem = hr;
		nxt.hue_q   = hq;
		nxt.sat_rem = sr;
		nxt.sat_lo  = sl;
		nxt.sat_q   = sq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

[hdl/rgb_to_hsv_converter.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// RGBA to HSV-A pixel converter, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the output is held off. Two front stages
// find max, min, delta and the hue sector, then four divider stages each
// resolve 4 hue bits and 2 saturation bits of two restoring dividers. The
// whole pipeline advances together; when the output is held off with a
// result waiting, pixel_ready drops, and bubbles keep their place. Hue is a
// 16-bit fraction of a turn, grey pixels give hue 0 and saturation 0,
// brightness is the largest channel, alpha passes through.
module rgb_to_hsv_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha_in,
	output logic        hsv_valid,
	input  logic        hsv_ready,
	output logic [15:0] hue,
	output logic [7:0]  saturation,
	output logic [7:0]  brightness,
	output logic [7:0]  alpha_out
);

	logic              advance;
	logic              v_c [rgb2hsv_pkg::DIV_STAGES+1];
	rgb2hsv_pkg::div_t d_c [rgb2hsv_pkg::DIV_STAGES+1];
	rgb2hsv_pkg::div_t last;

	assign advance     = !v_c[rgb2hsv_pkg::DIV_STAGES] || hsv_ready;
	assign pixel_ready = advance;

	rgb2hsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.v_in     (pixel_valid),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.alpha_in (alpha_in),
		.v_out    (v_c[0]),
		.d_out    (d_c[0])
	);

	for (genvar k = 0; k < rgb2hsv_pkg::DIV_STAGES; k++) begin : g_div
		rgb2hsv_div_stage u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.v_in   (v_c[k]),
			.d_in   (d_c[k]),
			.v_out  (v_c[k+1]),
			.d_out  (d_c[k+1])
		);
	end

	assign last       = d_c[rgb2hsv_pkg::DIV_STAGES];
	assign hsv_valid  = v_c[rgb2hsv_pkg::DIV_STAGES];
	assign hue        = last.grey ? '0 : last.hue_q;
	assign saturation = last.grey ? '0 : last.sat_q;
	assign brightness = last.brightness;
	assign alpha_out  = last.alpha;

`ifndef SYNTH
	// zero saturation only comes from a grey pixel
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && (saturation == '0) |-> (hue == '0))
		else $error("nonzero hue with zero saturation");

	a_stall_only_on_held_output: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> (hsv_valid && !hsv_ready))
		else $error("input stalled without a held result");

	// restoring divider remainder stays below the divisor
	a_hue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !last.grey |-> (last.hue_rem < last.hue_div))
		else $error("hue divider remainder out of range");
`endif

endmodule

[test/rgb_to_hsv_converter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_test
// Self-checking bench for the RGBA to HSV-A pixel converter. Each accepted
// pixel is converted by an integer HSV model in the bench and queued; every
// accepted result is checked field by field against the oldest entry. Runs
// grey/black pixels, sector ties, primaries and hue wrap, then random pixels
// under three flow-control mixes.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_test;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_PIXELS = 210;

	typedef struct {
		logic [15:0]         hue;
		rgb2hsv_pkg::chan_t  sat;
		rgb2hsv_pkg::chan_t  value;
		rgb2hsv_pkg::chan_t  alpha;
	} hsv_t;

	logic        clk;
	logic        arst_n;
	logic        pixel_valid;
	logic        pixel_ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha_in;
	logic        hsv_valid;
	logic        hsv_ready;
	logic [15:0] hue;
	logic [7:0]  saturation;
	logic [7:0]  brightness;
	logic [7:0]  alpha_out;

	hsv_t pending_hsv[$];
	int   failures = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   quiet_cycles = 0;

	rgb_to_hsv_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha_in(alpha_in),
		.hsv_valid(hsv_valid),
		.hsv_ready(hsv_ready),
		.hue(hue),
		.saturation(saturation),
		.brightness(brightness),
		.alpha_out(alpha_out)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic hsv_t hsv_of(rgb2hsv_pkg::chan_t r, rgb2hsv_pkg::chan_t g,
		rgb2hsv_pkg::chan_t b, rgb2hsv_pkg::chan_t a);
		rgb2hsv_pkg::chan_t   top;
		rgb2hsv_pkg::chan_t   bottom;
		int                   delta;
		int                   span;
		rgb2hsv_pkg::sector_t sector;
		hsv_t                 res;
		top = (r > g) ? r : g;
		top = (top > b) ? top : b;
		bottom = (r < g) ? r : g;
		bottom = (bottom < b) ? bottom : b;
		delta = int'(top) - int'(bottom);
		res.hue = '0;
		res.sat = '0;
		res.value = top;
		res.alpha = a;
		if (delta != 0) begin
			// ties resolve red, then green, then blue
			if (top == r)
				sector = rgb2hsv_pkg::SEC_RED;
			else if (top == g)
				sector = rgb2hsv_pkg::SEC_GREEN;
			else
				sector = rgb2hsv_pkg::SEC_BLUE;
			case (sector)
				rgb2hsv_pkg::SEC_RED:   span = int'(g) - int'(b);
				rgb2hsv_pkg::SEC_GREEN: span = 2 * delta + int'(b) - int'(r);
				default:                span = 4 * delta + int'(r) - int'(g);
			endcase
			if (span < 0)
				span += 6 * delta;
			res.hue = 16'((span * 65536) / (6 * delta));
		end
		if (top != 0)
			res.sat = 8'((delta * 255) / int'(top));
		return res;
	endfunction

	// Output side stalls at the configured rate
	always @(posedge clk) begin
		hsv_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Signals settle between edges; a handshake seen high here completes at the
	// next rising edge
	always @(negedge clk) begin
		hsv_t want;
		if (arst_n) begin
			if (pixel_valid && pixel_ready)
				pending_hsv.insert(pending_hsv.size(),
					hsv_of(red, green, blue, alpha_in));
			if (hsv_valid && hsv_ready) begin
				if (pending_hsv.size() == 0) begin
					$error("unexpected result: hue %0d sat %0d value %0d alpha %0d",
						hue, saturation, brightness, alpha_out);
					failures++;
				end else begin
					want = pending_hsv.pop_front();
					if (hue !== want.hue) begin
						$error("hue: expected %0d, actual %0d", want.hue, hue);
						failures++;
					end
					if (saturation !== want.sat) begin
						$error("saturation: expected %0d, actual %0d", want.sat, saturation);
						failures++;
					end
					if (brightness !== want.value) begin
						$error("brightness: expected %0d, actual %0d", want.value, brightness);
						failures++;
					end
					if (alpha_out !== want.alpha) begin
						$error("alpha_out: expected %0d, actual %0d", want.alpha, alpha_out);
						failures++;
					end
				end
			end
			if ((pixel_valid && pixel_ready) || (hsv_valid && hsv_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("rgb_to_hsv_converter_test NOT OK");
				$finish;
			end
		end
	end

	// Called at a rising edge; returns at the edge where the item is taken.
	// Valid stays high on return so back-to-back items need no extra edge.
	task automatic send_pixel(rgb2hsv_pkg::chan_t r, rgb2hsv_pkg::chan_t g,
		rgb2hsv_pkg::chan_t b, rgb2hsv_pkg::chan_t a);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		alpha_in <= a;
		do
			@(negedge clk);
		while (!pixel_ready);
		@(posedge clk);
	endtask

	task automatic test_grey_and_black();
		send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
		send_pixel(8'd128, 8'd128, 8'd128, 8'd170);
		send_pixel(8'd1, 8'd1, 8'd1, 8'd85);
	endtask

	task automatic test_sector_ties();
		send_pixel(8'd255, 8'd255, 8'd0, 8'd1);
		send_pixel(8'd200, 8'd0, 8'd200, 8'd2);
		send_pixel(8'd0, 8'd200, 8'd200, 8'd4);
		send_pixel(8'd90, 8'd90, 8'd30, 8'd8);
		send_pixel(8'd30, 8'd90, 8'd90, 8'd16);
	endtask

	task automatic test_primaries_and_wrap();
		send_pixel(8'd255, 8'd0, 8'd0, 8'd32);
		send_pixel(8'd0, 8'd255, 8'd0, 8'd64);
		send_pixel(8'd0, 8'd0, 8'd255, 8'd128);
		// red sector with blue above green goes negative and wraps
		send_pixel(8'd255, 8'd0, 8'd1, 8'd127);
		send_pixel(8'd255, 8'd0, 8'd254, 8'd254);
		send_pixel(8'd1, 8'd0, 8'd0, 8'd253);
		send_pixel(8'd0, 8'd1, 8'd0, 8'd251);
		send_pixel(8'd0, 8'd0, 8'd1, 8'd247);
		send_pixel(8'd255, 8'd254, 8'd0, 8'd239);
		send_pixel(8'd3, 8'd200, 8'd255, 8'd223);
		send_pixel(8'd255, 8'd1, 8'd0, 8'd191);
	endtask

	task automatic test_random_pixels(int count);
		rgb2hsv_pkg::chan_t r, g, b, base;
		int                 pick;
		for (int i = 0; i < count; i++) begin
			pick = int'($urandom_range(99));
			r = rgb2hsv_pkg::chan_t'($urandom);
			g = rgb2hsv_pkg::chan_t'($urandom);
			b = rgb2hsv_pkg::chan_t'($urandom);
			if (pick < 10) begin
				g = r;
				b = r;
			end else if (pick < 25) begin
				case ($urandom_range(2))
					0: g = r;
					1: b = g;
					default: r = b;
				endcase
			end else if (pick < 40) begin
				// near-grey: tiny delta stresses the divider
				base = rgb2hsv_pkg::chan_t'($urandom_range(252));
				r = base + 8'($urandom_range(3));
				g = base + 8'($urandom_range(3));
				b = base + 8'($urandom_range(3));
			end
			send_pixel(r, g, b, rgb2hsv_pkg::chan_t'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		alpha_in = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 72;
		test_grey_and_black();
		test_sector_ties();
		test_primaries_and_wrap();
		test_random_pixels(RANDOM_PIXELS);

		send_idle_pct = 72;
		recv_idle_pct = 37;
		test_random_pixels(RANDOM_PIXELS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_pixels(RANDOM_PIXELS);
		pixel_valid <= 1'b0;

		while (pending_hsv.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("rgb_to_hsv_converter_test OK");
		else
			$display("rgb_to_hsv_converter_test NOT OK");
		$finish;
	end

endmodule
